// ===== hdl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned StepW  = $clog2(DivSteps);

  typedef enum logic [FuncW-1:0] {
    K_NUM = 3'd0,
    K_ADD = 3'd1,
    K_SUB = 3'd2,
    K_MUL = 3'd3,
    K_DIV = 3'd4,
    K_END = 3'd5
  } kind_e;

  typedef enum logic [CodeW-1:0] {
    E_NONE      = 3'd0,
    E_MISSING   = 3'd1,
    E_DIVZERO   = 3'd2,
    E_OVERFLOW  = 3'd3,
    E_NOTSINGLE = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_FIN
  } state_e;

endpackage

// ===== hdl/rpn_if.sv =====
// ----------------------------------------------------------------------------
// rpn_if
// Valid/ready channels for tokens and expression results.
// ----------------------------------------------------------------------------
interface rpn_tok_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] operand;

  modport source (output valid, func, operand, input ready);
  modport sink   (input valid, func, operand, output ready);
endinterface

interface rpn_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               error_flag;
  logic [2:0]         error_code;

  modport source (output valid, value, error_flag, error_code, input ready);
  modport sink   (input valid, value, error_flag, error_code, output ready);
endinterface

// ===== hdl/rpn_expression_evaluator_top.sv =====
// Sequencing: number and end tokens are handled in the idle state; add, subtract and multiply
// read the stack, then execute in ST_EXEC; divide runs ST_EXEC, the radix-2 divider (32 steps), ST_FIN.
// Tokens are taken only in the idle state, not during an operation; the end token's result is registered and
// a new token is taken once that result is free or being taken.
// Reset: sequencer idle, stack empty, no error, no result pending; stack RAM not cleared.
// ----------------------------------------------------------------------------
// rpn_expression_evaluator_top
// Postfix integer expression evaluator with a RAM stack, a top-of-stack register
// and one iterative radix-2 divider.
// ----------------------------------------------------------------------------
module rpn_expression_evaluator_top #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpn_tok_if.sink    tok_i,
  rpn_res_if.source  res_o
);
  import rpn_pkg::*;

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam logic [CntW-1:0] FullCnt = CntW'(STACK_DEPTH);

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  err_e              err_q, err_d;
  kind_e             op_q, op_d;
  logic [DataW-1:0]  tos_q, tos_d;
  logic [DataW-1:0]  rem_q, rem_d;
  logic [DataW-1:0]  quo_q, quo_d;
  logic [DataW-1:0]  dvs_q, dvs_d;
  logic              neg_q, neg_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic [DataW-1:0]  out_value_q, out_value_d;
  err_e              out_code_q, out_code_d;

  logic              tok_ready;
  logic              tok_fire;
  logic [CntW-1:0]   cnt_m1, cnt_m2;
  logic              ram_we, ram_re;
  logic [DataW-1:0]  ram_rdata;
  logic [DataW:0]    trial;

  assign cnt_m1 = count_q - CntW'(1);
  assign cnt_m2 = count_q - CntW'(2);
  assign trial  = {rem_q, quo_q[DataW-1]} - {1'b0, dvs_q};

  rpn_ram #(
    .WIDTH(DataW),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_m1[AddrW-1:0]),
    .wdata_i(tos_q),
    .re_i   (ram_re),
    .raddr_i(cnt_m2[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign tok_ready = (state_q == ST_IDLE) && (!out_valid_q || res_o.ready);
  assign tok_fire  = tok_i.valid && tok_ready;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    err_d       = err_q;
    op_d        = op_q;
    tos_d       = tos_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dvs_d       = dvs_q;
    neg_d       = neg_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_value_d = out_value_q;
    out_code_d  = out_code_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (tok_fire) begin
          case (tok_i.func)
            K_END: begin
              out_valid_d = 1'b1;
              if (err_q != E_NONE) begin
                out_value_d = '1;
                out_code_d  = err_q;
              end else if (count_q == CntW'(1)) begin
                out_value_d = tos_q;
                out_code_d  = E_NONE;
              end else begin
                out_value_d = '1;
                out_code_d  = E_NOTSINGLE;
              end
              count_d = '0;
              err_d   = E_NONE;
            end
            K_NUM: begin
              if (err_q == E_NONE) begin
                if (count_q == FullCnt) begin
                  err_d = E_OVERFLOW;
                end else begin
                  ram_we  = (count_q != '0);
                  tos_d   = tok_i.operand;
                  count_d = count_q + CntW'(1);
                end
              end
            end
            K_ADD, K_SUB, K_MUL, K_DIV: begin
              if (err_q == E_NONE) begin
                if (count_q < CntW'(2)) begin
                  err_d = E_MISSING;
                end else if ((tok_i.func == K_DIV) && (tos_q == '0)) begin
                  err_d = E_DIVZERO;
                end else begin
                  ram_re  = 1'b1;
                  op_d    = kind_e'(tok_i.func);
                  state_d = ST_EXEC;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        case (op_q)
          K_ADD: begin
            tos_d   = ram_rdata + tos_q;
            count_d = cnt_m1;
          end
          K_SUB: begin
            tos_d   = ram_rdata - tos_q;
            count_d = cnt_m1;
          end
          K_MUL: begin
            tos_d   = ram_rdata * tos_q;
            count_d = cnt_m1;
          end
          K_DIV: begin
            neg_d   = ram_rdata[DataW-1] ^ tos_q[DataW-1];
            rem_d   = '0;
            quo_d   = ram_rdata[DataW-1] ? (~ram_rdata + DataW'(1)) : ram_rdata;
            dvs_d   = tos_q[DataW-1] ? (~tos_q + DataW'(1)) : tos_q;
            step_d  = '0;
            state_d = ST_DIV;
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        if (!trial[DataW]) begin
          rem_d = trial[DataW-1:0];
          quo_d = {quo_q[DataW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[DataW-2:0], quo_q[DataW-1]};
          quo_d = {quo_q[DataW-2:0], 1'b0};
        end
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        tos_d   = neg_q ? (~quo_q + DataW'(1)) : quo_q;
        count_d = cnt_m1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      err_q       <= E_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    tos_q       <= tos_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    dvs_q       <= dvs_d;
    neg_q       <= neg_d;
    step_q      <= step_d;
    out_value_q <= out_value_d;
    out_code_q  <= out_code_d;
  end

  assign tok_i.ready      = tok_ready;
  assign res_o.valid      = out_valid_q;
  assign res_o.value      = out_value_q;
  assign res_o.error_code = out_code_q;
  assign res_o.error_flag = (out_code_q != E_NONE);

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("stack count above depth");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_fire && (tok_i.func == K_END)) |=> (count_q == '0) && out_valid_q
      && (err_q == E_NONE))
    else $error("end transaction did not clear the stack");

  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_code_q != E_NONE)) |-> (out_value_q == '1))
    else $error("error result without all-ones value");

  a_div_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (count_q >= CntW'(2)) && (dvs_q != '0))
    else $error("divider running without two operands");
`endif

endmodule

// ===== hdl/rpn_ram.sv =====
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the postfix expression evaluator. A short table of
// tokens hits the operand extremes, every operator and each error path but
// overflow, then random expressions, stack floods and token noise are streamed
// through with bursty input and a stalling result side. Each result is checked
// against an in-bench stack machine.
// ----------------------------------------------------------------------------
module testbench;
  import rpn_pkg::*;

  localparam int unsigned StackDepth = 16;
  localparam int          DirCount   = 25;
  localparam int          RandItems  = 1000;
  localparam int          TailCycles = 40;
  localparam int          HoldCycles = 400;
  localparam int          CycleLimit = 400000;

  localparam logic [FuncW-1:0] KindSpare6 = 3'd6;
  localparam logic [FuncW-1:0] KindSpare7 = 3'd7;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             flag;
    err_e             code;
  } result_t;

  localparam result_t NoResult = '{32'hFFFF_FFFF, 1'b0, E_NONE};

  typedef struct {
    logic [FuncW-1:0] func;
    logic [DataW-1:0] operand;
    bit               typed;
    logic [DataW-1:0] exp_value;
    err_e             exp_code;
  } token_row_t;

  typedef enum {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_e;

  // directed tokens, typed expectations only where obvious
  token_row_t plan [DirCount] = '{
    '{K_END, 32'd0,         1'b1, 32'hFFFF_FFFF, E_NOTSINGLE},
    '{K_NUM, 32'h7FFF_FFFF, 1'b0, 32'd0,         E_NONE},
    '{K_NUM, 32'd1,         1'b0, 32'd0,         E_NONE},
    '{K_ADD, 32'd0,         1'b0, 32'd0,         E_NONE},
    '{K_END, 32'd0,         1'b1, 32'h8000_0000, E_NONE},
    '{K_NUM, 32'h8000_0000, 1'b0, 32'd0,         E_NONE},
    '{K_NUM, 32'hFFFF_FFFF, 1'b0, 32'd0,         E_NONE},
    '{K_DIV, 32'd0,         1'b0, 32'd0,         E_NONE},
    '{K_END, 32'd0,         1'b1, 32'h8000_0000, E_NONE},
    '{K_NUM, 32'd5,         1'b0, 32'd0,         E_NONE},
    '{K_SUB, 32'd0,         1'b0, 32'd0,         E_NONE},
    '{K_NUM, 32'd3,         1'b0, 32'd0,         E_NONE},
    '{K_END, 32'd0,         1'b1, 32'hFFFF_FFFF, E_MISSING},
    '{K_NUM, 32'd7,         1'b0, 32'd0,         E_NONE},
    '{K_NUM, 32'd0,         1'b0, 32'd0,         E_NONE},
    '{K_DIV, 32'd0,         1'b0, 32'd0,         E_NONE},
    '{KindSpare6, 32'hA5A5_5A5A, 1'b0, 32'd0,    E_NONE},
    '{K_END, 32'd0,         1'b1, 32'hFFFF_FFFF, E_DIVZERO},
    '{K_NUM, 32'hFFFF_FFF9, 1'b0, 32'd0,         E_NONE},
    '{K_NUM, 32'd2,         1'b0, 32'd0,         E_NONE},
    '{K_DIV, 32'd0,         1'b0, 32'd0,         E_NONE},
    '{K_NUM, 32'd3,         1'b0, 32'd0,         E_NONE},
    '{K_MUL, 32'd0,         1'b0, 32'd0,         E_NONE},
    '{KindSpare7, 32'h5A5A_A5A5, 1'b0, 32'd0,    E_NONE},
    '{K_END, 32'd0,         1'b0, 32'd0,         E_NONE}
  };

  logic clk_i;
  logic rst_ni;

  rpn_tok_if tok ();
  rpn_res_if res ();

  rpn_expression_evaluator_top #(
    .STACK_DEPTH(StackDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tok_i (tok),
    .res_o (res)
  );

  // shadow stack machine
  logic [DataW-1:0] shadow_stack [StackDepth];
  int unsigned      shadow_depth;
  err_e             shadow_error;

  result_t pending_results [$];
  result_t want;
  int      mismatches;
  int      cycles;
  int      tokens_sent;
  int      divides_sent;
  int      results_seen;
  int      codes_seen [5];
  int      burst_left;
  bit      hold_req;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic bit eval_token(input logic [FuncW-1:0] f,
                                    input logic [DataW-1:0] opnd,
                                    output result_t r);
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] ma;
    logic [DataW-1:0] mb;
    logic [DataW-1:0] acc;
    err_e             code;

    r = NoResult;
    if (f == K_END) begin
      code = shadow_error;
      if (code == E_NONE) begin
        if (shadow_depth == 1) r.value = shadow_stack[0];
        else code = E_NOTSINGLE;
      end
      r.code = code;
      r.flag = (code != E_NONE);
      shadow_depth = 0;
      shadow_error = E_NONE;
      return 1'b1;
    end
    if (f > K_END || shadow_error != E_NONE) return 1'b0;
    if (f == K_NUM) begin
      if (shadow_depth >= StackDepth) begin
        shadow_error = E_OVERFLOW;
      end else begin
        shadow_stack[shadow_depth] = opnd;
        shadow_depth++;
      end
      return 1'b0;
    end
    if (shadow_depth < 2) begin
      shadow_error = E_MISSING;
      return 1'b0;
    end
    a = shadow_stack[shadow_depth-1];
    b = shadow_stack[shadow_depth-2];
    case (f)
      K_ADD: acc = b + a;
      K_SUB: acc = b - a;
      K_MUL: acc = b * a;
      default: begin
        if (a == '0) begin
          shadow_error = E_DIVZERO;
          return 1'b0;
        end
        // truncating divide on magnitudes, min / -1 wraps
        mb  = b[DataW-1] ? (32'd0 - b) : b;
        ma  = a[DataW-1] ? (32'd0 - a) : a;
        acc = mb / ma;
        if (a[DataW-1] ^ b[DataW-1]) acc = 32'd0 - acc;
      end
    endcase
    shadow_depth--;
    shadow_stack[shadow_depth-1] = acc;
    return 1'b0;
  endfunction

  function automatic logic [DataW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return 32'($urandom_range(0, 32)) - 32'd16;
      7:          return 32'h8000_0000;
      8:          return 32'h7FFF_FFFF;
      default:    return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
    endcase
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic send_token(input logic [FuncW-1:0] f, input logic [DataW-1:0] opnd,
                            input bit typed = 1'b0, input result_t typed_res = NoResult);
    result_t r;
    bit      has_res;
    int      gap;

    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        tok.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    tok.valid   <= 1'b1;
    tok.func    <= f;
    tok.operand <= opnd;
    do @(posedge clk_i); while (!tok.ready);
    has_res = eval_token(f, opnd, r);
    if (has_res) pending_results.push_back(typed ? typed_res : r);
    if (f <= K_END) tokens_sent++;
    if (f == K_DIV) divides_sent++;
  endtask

  task automatic wait_for_results();
    tok.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    burst_left = 0;
  endtask

  task automatic stream_expression();
    int               shape;
    int               depth_v;
    int               steps;
    int               push_pct;
    logic [FuncW-1:0] op;

    shape = $urandom_range(0, 9);
    if (shape <= 6) begin
      // well-formed body, shape 6 leaves the stack unreduced
      depth_v  = 0;
      steps    = $urandom_range(1, 24);
      push_pct = $urandom_range(20, 75);
      repeat (steps) begin
        if (depth_v < 2 || (depth_v < StackDepth && $urandom_range(0, 99) < push_pct)) begin
          send_token(K_NUM, pick_operand());
          depth_v++;
        end else begin
          op = K_ADD + 3'($urandom_range(0, 3));
          send_token(op, $urandom);
          depth_v--;
        end
      end
      if (shape != 6) begin
        while (depth_v > 1) begin
          op = K_ADD + 3'($urandom_range(0, 3));
          send_token(op, $urandom);
          depth_v--;
        end
      end
    end else if (shape == 7) begin
      // fill the stack to near, up to or past its depth
      repeat ($urandom_range(StackDepth - 2, StackDepth + 3)) send_token(K_NUM, pick_operand());
      repeat ($urandom_range(0, 3)) send_token(K_ADD + 3'($urandom_range(0, 3)), $urandom);
    end else begin
      repeat ($urandom_range(1, 10)) send_token(3'($urandom_range(0, 7)), $urandom);
    end
    send_token(K_END, $urandom);
  endtask

  // result side stall pattern
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       hold_left;
    int       sparse_phase;

    res.ready    = 1'b0;
    mode         = RX_OPEN;
    mode_left    = 0;
    hold_left    = 0;
    sparse_phase = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        sparse_phase = (sparse_phase + 1) % 4;
        case (mode)
          RX_OPEN:   res.ready <= 1'b1;
          RX_RANDOM: res.ready <= ($urandom_range(0, 1) != 0);
          default:   res.ready <= (sparse_phase == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      results_seen++;
      if (res.error_code <= E_NOTSINGLE) codes_seen[res.error_code]++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result value %0d flag %0b code %0d",
                         res.value, res.error_flag, res.error_code));
      end else begin
        want = pending_results.pop_front();
        if (res.value !== want.value || res.error_flag !== want.flag ||
            res.error_code !== want.code) begin
          report($sformatf("value %0d/%0d flag %0b/%0b code %0d/%0d (expected/actual)",
                           $signed(want.value), res.value, want.flag, res.error_flag,
                           want.code, res.error_code));
        end
      end
    end
  end

  initial begin
    result_t row_res;
    bit      hold_done;
    bit      drain_done;

    rst_ni       = 1'b0;
    tok.valid    = 1'b0;
    tok.func     = K_NUM;
    tok.operand  = '0;
    hold_req     = 1'b0;
    hold_done    = 1'b0;
    drain_done   = 1'b0;
    burst_left   = 0;
    shadow_depth = 0;
    shadow_error = E_NONE;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      row_res = '{plan[i].exp_value, plan[i].exp_code != E_NONE, plan[i].exp_code};
      send_token(plan[i].func, plan[i].operand, plan[i].typed, row_res);
    end

    while (tokens_sent < DirCount + RandItems) begin
      if (!hold_done && tokens_sent > 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && tokens_sent > 600) begin
        wait_for_results();
        drain_done = 1'b1;
      end
      stream_expression();
    end

    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("sent %0d tokens (%0d divides), checked %0d results", tokens_sent,
             divides_sent, results_seen);
    $display("by code: ok %0d, missing %0d, div0 %0d, overflow %0d, not single %0d",
             codes_seen[E_NONE], codes_seen[E_MISSING], codes_seen[E_DIVZERO],
             codes_seen[E_OVERFLOW], codes_seen[E_NOTSINGLE]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== rpn_expression_evaluator_top.f =====
hdl/rpn_pkg.sv
hdl/rpn_if.sv
hdl/rpn_ram.sv
hdl/rpn_expression_evaluator_top.sv
bench/testbench.sv
